// ===== design/btt_pkg.sv =====
// Shared widths, types and register codes for the barycentric triangle test.
package btt_pkg;

    localparam int COORD_BITS  = 12;
    localparam int WEIGHT_BITS = 16;

    // Derived arithmetic widths.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int NA_W   = NUM_W + 2;
    localparam int MAG_W  = PROD_W;

    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    // Division lanes, one per weight.
    localparam int LANES      = 3;
    localparam int LANE_ALPHA = 0;
    localparam int LANE_BETA  = 1;
    localparam int LANE_GAMMA = 2;

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [NUM_W-1:0]       num_t;
    typedef logic signed [NA_W-1:0]        na_t;
    typedef logic [MAG_W-1:0]              mag_t;
    typedef logic [WEIGHT_BITS-1:0]        weight_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5
    } cfg_reg_t;

    // One request as it moves down the divider chain.
    typedef struct packed {
        logic                   valid;
        logic                   in_tri;
        mag_t    [LANES-1:0]    rem;
        weight_t [LANES-1:0]    quo;
    } div_slot_t;

    // One finished result.
    typedef struct packed {
        logic    in_tri;
        weight_t alpha;
        weight_t beta;
        weight_t gamma;
    } res_t;

endpackage

// ===== design/btt_pix_if.sv =====
// Pixel request channel: valid, ready and the pixel coordinates.
interface btt_pix_if import btt_pkg::*; ;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);

endinterface

// ===== design/btt_res_if.sv =====
// Result channel: valid, ready, the inside flag and the three weights.
interface btt_res_if import btt_pkg::*; ;

    logic    valid;
    logic    ready;
    logic    inside_res;
    weight_t weight_alpha;
    weight_t weight_beta;
    weight_t weight_gamma;

    modport source (output valid, output inside_res, output weight_alpha,
                    output weight_beta, output weight_gamma, input ready);
    modport sink   (input valid, input inside_res, input weight_alpha,
                    input weight_beta, input weight_gamma, output ready);

endinterface

// ===== design/barycentric_triangle_test.sv =====
// A result passes the numerator stages, the division chain and the output register.
// Throughput: one pixel per cycle while the output buffer is not full; the chain of 16
// division cells, one per weight bit, and the numerator stages all advance together.
// A two-entry output buffer keeps ready registered; ready drops only when both are full.
// Reset clears the vertex registers to zero and empties the pipeline.
// Vertex writes take effect for pixels accepted in the following cycle or later.
module barycentric_triangle_test import btt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  coord_t    cfg_data,
    btt_pix_if.sink   pixel,
    btt_res_if.source result
);

    logic      adv;
    mag_t      det;
    div_slot_t slot [WEIGHT_BITS+1];

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    res_t      out_reg, out_next;
    res_t      skid_reg, skid_next;
    res_t      last_res;
    logic      arrival;
    logic      take;

    // The whole pipeline moves unless the output buffer is full.
    assign adv         = !skid_valid_reg;
    assign pixel.ready = adv;

    btt_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (pixel.valid),
        .pixel_x   (pixel.pixel_x),
        .pixel_y   (pixel.pixel_y),
        .det       (det),
        .slot      (slot[0])
    );

    // Division chain, one cell per weight bit, most significant first.
    for (genvar i = 0; i < WEIGHT_BITS; i++)
    begin : g_cell
        btt_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .det   (det),
            .prev  (slot[i]),
            .cur   (slot[i+1])
        );
    end

    always_comb
    begin
        last_res.in_tri = slot[WEIGHT_BITS].in_tri;
        last_res.alpha  = slot[WEIGHT_BITS].quo[LANE_ALPHA];
        last_res.beta   = slot[WEIGHT_BITS].quo[LANE_BETA];
        last_res.gamma  = slot[WEIGHT_BITS].quo[LANE_GAMMA];
    end

    assign arrival = adv && slot[WEIGHT_BITS].valid;
    assign take    = out_valid_reg && result.ready;

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (arrival)
            begin
                out_next       = last_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (arrival)
        begin
            skid_next       = last_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.inside_res   = out_reg.in_tri;
    assign result.weight_alpha = out_reg.alpha;
    assign result.weight_beta  = out_reg.beta;
    assign result.weight_gamma = out_reg.gamma;

endmodule

// ===== design/btt_geom.sv =====
// Vertex registers, edge and determinant setup, and the numerator pipeline.
module btt_geom import btt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      cfg_we,
    input  cfg_idx_t  cfg_index,
    input  coord_t    cfg_data,
    input  logic      in_valid,
    input  coord_t    pixel_x,
    input  coord_t    pixel_y,
    output mag_t      det,
    output div_slot_t slot
);

    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    coord_t ax_next, ay_next, bx_next, by_next, cx_next, cy_next;

    diff_t e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    diff_t e1x_next, e1y_next, e2x_next, e2y_next;
    prod_t dp0_reg, dp1_reg, dp0_next, dp1_next;
    num_t  det_raw_reg, det_raw_next;
    mag_t  det_abs_reg, det_abs_next;
    logic  det_neg;

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    diff_t px1_reg, py1_reg, px1_next, py1_next;
    prod_t pb0_reg, pb1_reg, pg0_reg, pg1_reg;
    prod_t pb0_next, pb1_next, pg0_next, pg1_next;
    num_t  nb3_reg, ng3_reg, nb3_next, ng3_next;
    num_t  nb4_reg, ng4_reg, nb4_next, ng4_next;
    na_t   na5_reg, na5_next;
    mag_t  nb5_reg, ng5_reg;
    logic  fb5_reg, fg5_reg, fb5_next, fg5_next;
    logic  inside6_next;
    div_slot_t slot6_reg, slot6_next;

    // Configuration writes; unknown indexes are ignored.
    always_comb
    begin
        ax_next = ax_reg;
        ay_next = ay_reg;
        bx_next = bx_reg;
        by_next = by_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_A_X: ax_next = cfg_data;
                REG_A_Y: ay_next = cfg_data;
                REG_B_X: bx_next = cfg_data;
                REG_B_Y: by_next = cfg_data;
                REG_C_X: cx_next = cfg_data;
                REG_C_Y: cy_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Per-triangle setup: edges, determinant products, determinant, magnitude.
    always_comb
    begin
        e1x_next     = diff_t'({1'b0, bx_reg}) - diff_t'({1'b0, ax_reg});
        e1y_next     = diff_t'({1'b0, by_reg}) - diff_t'({1'b0, ay_reg});
        e2x_next     = diff_t'({1'b0, cx_reg}) - diff_t'({1'b0, ax_reg});
        e2y_next     = diff_t'({1'b0, cy_reg}) - diff_t'({1'b0, ay_reg});
        dp0_next     = e1x_reg * e2y_reg;
        dp1_next     = e2x_reg * e1y_reg;
        det_raw_next = num_t'(dp0_reg) - num_t'(dp1_reg);
        det_abs_next = det_raw_reg[NUM_W-1] ? mag_t'(-det_raw_reg) : mag_t'(det_raw_reg);
    end

    assign det_neg = det_raw_reg[NUM_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg      <= '0;
            ay_reg      <= '0;
            bx_reg      <= '0;
            by_reg      <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            e1x_reg     <= '0;
            e1y_reg     <= '0;
            e2x_reg     <= '0;
            e2y_reg     <= '0;
            dp0_reg     <= '0;
            dp1_reg     <= '0;
            det_raw_reg <= '0;
            det_abs_reg <= '0;
        end
        else
        begin
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            e1x_reg     <= e1x_next;
            e1y_reg     <= e1y_next;
            e2x_reg     <= e2x_next;
            e2y_reg     <= e2y_next;
            dp0_reg     <= dp0_next;
            dp1_reg     <= dp1_next;
            det_raw_reg <= det_raw_next;
            det_abs_reg <= det_abs_next;
        end
    end

    // Per-pixel numerator stages.
    always_comb
    begin
        px1_next = diff_t'({1'b0, pixel_x}) - diff_t'({1'b0, ax_reg});
        py1_next = diff_t'({1'b0, pixel_y}) - diff_t'({1'b0, ay_reg});

        pb0_next = e2y_reg * px1_reg;
        pb1_next = e2x_reg * py1_reg;
        pg0_next = e1x_reg * py1_reg;
        pg1_next = e1y_reg * px1_reg;

        nb3_next = num_t'(pb0_reg) - num_t'(pb1_reg);
        ng3_next = num_t'(pg0_reg) - num_t'(pg1_reg);

        // Flip the signs for a clockwise triangle.
        nb4_next = det_neg ? -nb3_reg : nb3_reg;
        ng4_next = det_neg ? -ng3_reg : ng3_reg;

        na5_next = na_t'(det_abs_reg) - na_t'(nb4_reg) - na_t'(ng4_reg);
        fb5_next = !nb4_reg[NUM_W-1] && (nb4_reg != '0) && (mag_t'(nb4_reg) < det_abs_reg);
        fg5_next = !ng4_reg[NUM_W-1] && (ng4_reg != '0) && (mag_t'(ng4_reg) < det_abs_reg);

        // A zero determinant fails the beta range check, so it lands outside.
        inside6_next = fb5_reg && fg5_reg && !na5_reg[NA_W-1] && (na5_reg != '0)
                       && (mag_t'(na5_reg) < det_abs_reg);

        slot6_next                  = '0;
        slot6_next.valid            = v5_reg;
        slot6_next.in_tri           = inside6_next;
        slot6_next.rem[LANE_ALPHA]  = inside6_next ? mag_t'(na5_reg) : '0;
        slot6_next.rem[LANE_BETA]   = inside6_next ? nb5_reg : '0;
        slot6_next.rem[LANE_GAMMA]  = inside6_next ? ng5_reg : '0;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1_reg   <= px1_next;
            py1_reg   <= py1_next;
            pb0_reg   <= pb0_next;
            pb1_reg   <= pb1_next;
            pg0_reg   <= pg0_next;
            pg1_reg   <= pg1_next;
            nb3_reg   <= nb3_next;
            ng3_reg   <= ng3_next;
            nb4_reg   <= nb4_next;
            ng4_reg   <= ng4_next;
            na5_reg   <= na5_next;
            nb5_reg   <= mag_t'(nb4_reg);
            ng5_reg   <= mag_t'(ng4_reg);
            fb5_reg   <= fb5_next;
            fg5_reg   <= fg5_next;
            slot6_reg <= slot6_next;
        end
    end

    always_comb
    begin
        slot       = slot6_reg;
        slot.valid = v6_reg;
    end

    assign det = det_abs_reg;

endmodule

// ===== design/btt_div_cell.sv =====
// One restoring-division cell: one quotient bit for each of the three weights.
module btt_div_cell import btt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  mag_t      det,
    input  div_slot_t prev,
    output div_slot_t cur
);

    div_slot_t        slot_reg, slot_next;
    logic [MAG_W:0]   dbl [LANES];

    // Double the remainder and subtract the determinant where it fits.
    // Outside pixels keep all quotient bits at zero, even for a zero determinant.
    always_comb
    begin
        slot_next        = prev;
        for (int l = 0; l < LANES; l++)
        begin
            dbl[l] = {prev.rem[l], 1'b0};
            if (prev.in_tri && (dbl[l] >= {1'b0, det}))
            begin
                slot_next.rem[l] = mag_t'(dbl[l] - {1'b0, det});
                slot_next.quo[l] = {prev.quo[l][WEIGHT_BITS-2:0], 1'b1};
            end
            else
            begin
                slot_next.rem[l] = mag_t'(dbl[l]);
                slot_next.quo[l] = {prev.quo[l][WEIGHT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (adv)
        begin
            slot_reg <= slot_next;
        end
    end

    assign cur = slot_reg;

endmodule

// ===== tb/barycentric_triangle_test_test.sv =====
// Testbench for the barycentric point-in-triangle block: directed and random pixels checked.
module barycentric_triangle_test_test;
    import btt_pkg::*;

    localparam int      COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      DRAIN_CYCLES  = 40;
    localparam int      BATCH_PIXELS  = 50;
    localparam int      MAX_REPORTS   = 10;
    localparam cfg_idx_t UNUSED_IDX_LO = cfg_idx_t'(NUM_REGS);
    localparam cfg_idx_t UNUSED_IDX_HI = cfg_idx_t'(NUM_REGS + 1);

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    coord_t   cfg_data;

    btt_pix_if pixel_ch ();
    btt_res_if result_ch ();

    // Shadow copy of the vertex registers as the block should hold them.
    coord_t vertex_reg [NUM_REGS];
    // Results owed by the block, oldest first.
    res_t   weights_due [$];

    int fail_count;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int cycle_count;

    barycentric_triangle_test uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch.sink),
        .result    (result_ch.source)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Exact barycentric weights of one pixel against the shadow triangle.
    function automatic res_t predict_barycentric(coord_t pix_x, coord_t pix_y);
        longint ax, ay, e1x, e1y, e2x, e2y, dx, dy;
        longint det, num_a, num_b, num_g;
        res_t   res;
        ax    = longint'(vertex_reg[REG_A_X]);
        ay    = longint'(vertex_reg[REG_A_Y]);
        e1x   = longint'(vertex_reg[REG_B_X]) - ax;
        e1y   = longint'(vertex_reg[REG_B_Y]) - ay;
        e2x   = longint'(vertex_reg[REG_C_X]) - ax;
        e2y   = longint'(vertex_reg[REG_C_Y]) - ay;
        dx    = longint'(pix_x) - ax;
        dy    = longint'(pix_y) - ay;
        det   = e1x * e2y - e2x * e1y;
        num_b = e2y * dx - e2x * dy;
        num_g = e1x * dy - e1y * dx;
        res   = '0;
        // A clockwise triangle is flipped so the sign test is order-free.
        if (det < 0)
        begin
            det   = -det;
            num_b = -num_b;
            num_g = -num_g;
        end
        num_a = det - num_b - num_g;
        if (det != 0 && num_a > 0 && num_a < det && num_b > 0 && num_b < det &&
            num_g > 0 && num_g < det)
        begin
            res.in_tri = 1'b1;
            res.alpha  = weight_t'((num_a <<< WEIGHT_BITS) / det);
            res.beta   = weight_t'((num_b <<< WEIGHT_BITS) / det);
            res.gamma  = weight_t'((num_g <<< WEIGHT_BITS) / det);
        end
        return res;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Compare one accepted result with the oldest owed one.
    task automatic check_result();
        res_t want;
        if (weights_due.size() == 0)
        begin
            note_failure($sformatf("unexpected result inside=%0d a=%0d b=%0d g=%0d",
                result_ch.inside_res, result_ch.weight_alpha, result_ch.weight_beta,
                result_ch.weight_gamma));
        end
        else
        begin
            want = weights_due.pop_front();
            if (result_ch.inside_res !== want.in_tri || result_ch.weight_alpha !== want.alpha ||
                result_ch.weight_beta !== want.beta || result_ch.weight_gamma !== want.gamma)
                note_failure($sformatf(
                    "expected inside=%0d a=%0d b=%0d g=%0d, got inside=%0d a=%0d b=%0d g=%0d",
                    want.in_tri, want.alpha, want.beta, want.gamma,
                    result_ch.inside_res, result_ch.weight_alpha, result_ch.weight_beta,
                    result_ch.weight_gamma));
        end
    endtask

    // Result side: checks each accepted result and drives ready, with long holds on request.
    initial
    begin
        int hold_left;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_result();
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Offer one pixel request, after a random gap, and wait until it is taken.
    task automatic offer_pixel(coord_t pix_x, coord_t pix_y);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.pixel_x <= pix_x;
        pixel_ch.pixel_y <= pix_y;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        weights_due.insert(weights_due.size(), predict_barycentric(pix_x, pix_y));
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic quiesce();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (weights_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, coord_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx < NUM_REGS)
            vertex_reg[idx] = value;
    endtask

    // Load all six vertex registers, then poke the unused indexes, which must be ignored.
    task automatic load_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                 coord_t cx, coord_t cy);
        write_reg(REG_A_X, ax);
        write_reg(REG_A_Y, ay);
        write_reg(REG_B_X, bx);
        write_reg(REG_B_Y, by);
        write_reg(REG_C_X, cx);
        write_reg(REG_C_Y, cy);
        write_reg(UNUSED_IDX_LO, coord_t'($urandom));
        write_reg(UNUSED_IDX_HI, coord_t'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Random triangle: mostly large, some tiny, some on the corners, some degenerate.
    task automatic load_random_triangle();
        coord_t v [NUM_REGS];
        int     kind;
        int     base [2];
        kind    = $urandom_range(99);
        base[0] = $urandom_range(COORD_MAX - 63);
        base[1] = $urandom_range(COORD_MAX - 63);
        foreach (v[i])
        begin
            if (kind < 60 || kind >= 92)
                v[i] = coord_t'($urandom);
            else if (kind < 80)
                v[i] = coord_t'(base[i % 2] + $urandom_range(63));
            else
                v[i] = $urandom_range(1) ? coord_t'(COORD_MAX) : '0;
        end
        if (kind >= 92)
        begin
            v[REG_C_X] = v[REG_B_X];
            v[REG_C_Y] = v[REG_B_Y];
        end
        load_triangle(v[REG_A_X], v[REG_A_Y], v[REG_B_X], v[REG_B_Y], v[REG_C_X], v[REG_C_Y]);
    endtask

    // Pixel mostly in the triangle's bounding box, some on vertices, edge midpoints or anywhere.
    function automatic void choose_pixel(output coord_t pix_x, output coord_t pix_y);
        int xs [3];
        int ys [3];
        int lo_x, hi_x, lo_y, hi_y;
        int pick, j, k;
        xs   = '{vertex_reg[REG_A_X], vertex_reg[REG_B_X], vertex_reg[REG_C_X]};
        ys   = '{vertex_reg[REG_A_Y], vertex_reg[REG_B_Y], vertex_reg[REG_C_Y]};
        lo_x = xs[0];
        hi_x = xs[0];
        lo_y = ys[0];
        hi_y = ys[0];
        foreach (xs[i])
        begin
            if (xs[i] < lo_x) lo_x = xs[i];
            if (xs[i] > hi_x) hi_x = xs[i];
            if (ys[i] < lo_y) lo_y = ys[i];
            if (ys[i] > hi_y) hi_y = ys[i];
        end
        pick = $urandom_range(99);
        j    = $urandom_range(2);
        k    = (j + 1) % 3;
        if (pick < 70)
        begin
            pix_x = coord_t'($urandom_range(hi_x, lo_x));
            pix_y = coord_t'($urandom_range(hi_y, lo_y));
        end
        else if (pick < 75)
        begin
            pix_x = coord_t'(xs[j]);
            pix_y = coord_t'(ys[j]);
        end
        else if (pick < 82)
        begin
            pix_x = coord_t'((xs[j] + xs[k]) / 2);
            pix_y = coord_t'((ys[j] + ys[k]) / 2);
        end
        else
        begin
            pix_x = coord_t'($urandom);
            pix_y = coord_t'($urandom);
        end
    endfunction

    // After reset all vertices sit at the origin, so nothing is inside.
    task automatic test_reset_state();
        offer_pixel('0, '0);
        offer_pixel(coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        quiesce();
    endtask

    // A fixed triangle: interior, vertex, edge midpoints and far corners.
    task automatic test_known_triangle();
        load_triangle(12'd100, 12'd100, 12'd1100, 12'd200, 12'd400, 12'd1300);
        offer_pixel(12'd533, 12'd533);
        offer_pixel(12'd100, 12'd100);
        offer_pixel(12'd600, 12'd150);
        offer_pixel(12'd750, 12'd750);
        offer_pixel('0, '0);
        offer_pixel(coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        offer_pixel(coord_t'(COORD_MAX), '0);
        offer_pixel('0, coord_t'(COORD_MAX));
        quiesce();
    endtask

    // Same triangle with swapped vertices, then the largest triangles the range allows.
    task automatic test_orientation_and_extremes();
        load_triangle(12'd100, 12'd100, 12'd400, 12'd1300, 12'd1100, 12'd200);
        offer_pixel(12'd533, 12'd533);
        offer_pixel(12'd600, 12'd150);
        offer_pixel(12'd300, 12'd300);
        quiesce();
        load_triangle('0, '0, coord_t'(COORD_MAX), '0, '0, coord_t'(COORD_MAX));
        offer_pixel(12'd1, 12'd1);
        offer_pixel(12'd2047, 12'd2047);
        offer_pixel(12'd2048, 12'd2047);
        offer_pixel('0, '0);
        quiesce();
        load_triangle(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0,
                      '0, coord_t'(COORD_MAX));
        offer_pixel(12'd4094, 12'd4094);
        offer_pixel(coord_t'(COORD_MAX), 12'd2000);
        quiesce();
    endtask

    // Collinear vertices give a zero determinant: every pixel is outside.
    task automatic test_degenerate();
        load_triangle('0, '0, 12'd2000, 12'd2000, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        offer_pixel(12'd1000, 12'd1000);
        offer_pixel(12'd1000, 12'd1001);
        quiesce();
    endtask

    // Random triangles in batches, each batch loaded while the block is idle.
    task automatic test_random_traffic(int idle_pct, int stall_pct, int pixels);
        coord_t pix_x, pix_y;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int sent = 0; sent < pixels; sent += BATCH_PIXELS)
        begin
            load_random_triangle();
            repeat (BATCH_PIXELS)
            begin
                choose_pixel(pix_x, pix_y);
                offer_pixel(pix_x, pix_y);
            end
            quiesce();
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        coord_t pix_x, pix_y;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        load_triangle(12'd50, 12'd80, 12'd3900, 12'd300, 12'd1800, 12'd4000);
        hold_request = 300;
        repeat (120)
        begin
            choose_pixel(pix_x, pix_y);
            offer_pixel(pix_x, pix_y);
        end
        quiesce();
    endtask

    // Test sequence.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        pixel_ch.valid   = 1'b0;
        pixel_ch.pixel_x = '0;
        pixel_ch.pixel_y = '0;
        fail_count       = 0;
        sender_idle_pct  = 0;
        recv_stall_pct   = 0;
        hold_request     = 0;
        foreach (vertex_reg[i])
            vertex_reg[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_known_triangle();
        test_orientation_and_extremes();
        test_degenerate();
        test_random_traffic(0, 0, 300);
        test_random_traffic(88, 0, 300);
        test_random_traffic(0, 88, 300);
        test_random_traffic(15, 15, 300);
        test_backpressure();

        recv_stall_pct = 0;
        while (weights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/btt_pkg.sv
design/btt_pix_if.sv
design/btt_res_if.sv
design/btt_geom.sv
design/btt_div_cell.sv
design/barycentric_triangle_test.sv
tb/barycentric_triangle_test_test.sv
